// ----- rtl/keyed_lru_result_cache_assert.svh -----
// assertion macros for the keyed lru result cache
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef KEYED_LRU_RESULT_CACHE_ASSERT_SVH
`define KEYED_LRU_RESULT_CACHE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KLRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("klrc assertion failed");

// next-cycle implication, checked out of reset
`define KLRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("klrc assertion failed");

`endif

// ----- rtl/klrc_pkg.sv -----
// types and constants shared by the keyed lru result cache
// no dependencies
package klrc_pkg;

  localparam int unsigned DefCacheEntries = 16;
  localparam int unsigned WordsPerEntry   = 4;
  localparam int unsigned WordW           = 64;
  localparam int unsigned ElementW        = 7;

  typedef enum logic [0:0] {
    CMD_LOOKUP = 1'b0,
    CMD_FILL   = 1'b1
  } cmd_e;

  // input transaction
  typedef struct packed {
    cmd_e                cmd;
    logic [ElementW-1:0] element_z;
    logic [WordW-1:0]    energy_bits;
    logic [WordW-1:0]    fill_photoelectric;
    logic [WordW-1:0]    fill_compton;
    logic [WordW-1:0]    fill_rayleigh;
    logic [WordW-1:0]    fill_pair;
  } req_t;

  // output transaction
  typedef struct packed {
    logic             hit;
    logic [WordW-1:0] out_photoelectric;
    logic [WordW-1:0] out_compton;
    logic [WordW-1:0] out_rayleigh;
    logic [WordW-1:0] out_pair;
  } rsp_t;

  typedef struct packed {
    logic [ElementW-1:0] element;
    logic [WordW-1:0]    energy;
  } key_t;

  typedef logic [WordsPerEntry-1:0][WordW-1:0] words_t;

  typedef struct packed {
    key_t   key;
    words_t words;
  } entry_t;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic accept;
    logic fill;
    logic hit_any;
  } cell_ctl_t;

endpackage

// ----- rtl/klrc_cell.sv -----
// one cache slot: holds a key and its value words, compares against the
// lookup key and loads from its front neighbor on a shift; uses klrc_pkg
module klrc_cell import klrc_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      valid_i,
  input  key_t      key_i,
  input  entry_t    shift_in_i,
  input  logic      found_i,
  output logic      found_o,
  output logic      sel_o,
  output entry_t    entry_o
);

  entry_t entry_q, entry_d;
  logic   match;
  logic   load;

  // key compare, only on filled slots
  assign match = valid_i && (entry_q.key == key_i);

  // first match along the chain owns the hit
  assign sel_o   = match && !found_i;
  assign found_o = found_i || match;

  // shift on every fill, or up to and including the hit slot on a lookup
  assign load = ctl_i.accept && (ctl_i.fill || (ctl_i.hit_any && !found_i));

  always_comb begin
    entry_d = entry_q;
    if (load) begin
      entry_d = shift_in_i;
    end
  end

  // slot payload, no reset needed
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- rtl/keyed_lru_result_cache.sv -----
// channel  | valid       | stall        | payload
// ---------+-------------+--------------+------------------
// request  | in_valid_i  | in_stall_o   | in_data_i  (req_t)
// response | out_valid_o | out_stall_i  | out_data_o (rsp_t)
//
// one transaction per cycle while in_stall_o is low: the compare across the cell chain, the first-hit
// ripple, the hit word select and the shift all finish in the accept cycle
// response appears in the cycle after accept, from the output register
// reset clears the fill count and output valid; slot contents stay undefined
// a stalled response holds the request side only when the output register
// is full and not being taken
//
// top level of the keyed lru result cache; uses klrc_pkg, klrc_cell and
// keyed_lru_result_cache_assert.svh
module keyed_lru_result_cache import klrc_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = DefCacheEntries
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam int unsigned CntW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(CACHE_ENTRIES);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_data_q, out_data_d;

  logic                     acc;
  logic                     is_fill;
  logic                     count_grow;
  key_t                     key;
  words_t                   fill_words;
  words_t                   hit_words;
  entry_t                   front;
  cell_ctl_t                ctl;
  logic [CACHE_ENTRIES:0]   found;
  logic [CACHE_ENTRIES-1:0] sel;
  entry_t                   cell_entry [CACHE_ENTRIES];

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign is_fill    = (in_data_i.cmd == CMD_FILL);
  assign count_grow = acc && is_fill && (count_q != CntMax);

  assign key.element = in_data_i.element_z;
  assign key.energy  = in_data_i.energy_bits;
  assign fill_words  = {in_data_i.fill_photoelectric, in_data_i.fill_compton,
                        in_data_i.fill_rayleigh, in_data_i.fill_pair};

  assign ctl.accept  = acc;
  assign ctl.fill    = is_fill;
  assign ctl.hit_any = found[CACHE_ENTRIES];

  // cell chain, slot 0 at the front
  assign found[0] = 1'b0;

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    entry_t shift_in;
    if (i == 0) begin : g_front
      assign shift_in = front;
    end else begin : g_back
      assign shift_in = cell_entry[i-1];
    end

    klrc_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .valid_i    (count_q > CntW'(i)),
      .key_i      (key),
      .shift_in_i (shift_in),
      .found_i    (found[i]),
      .found_o    (found[i+1]),
      .sel_o      (sel[i]),
      .entry_o    (cell_entry[i])
    );
  end

  // one-hot select of the hit slot's words, zero on a miss
  always_comb begin
    hit_words = '0;
    for (int unsigned i = 0; i < CACHE_ENTRIES; i++) begin
      hit_words = hit_words | (sel[i] ? cell_entry[i].words : '0);
    end
  end

  // entry written at the front
  assign front.key   = key;
  assign front.words = is_fill ? fill_words : hit_words;

  // fill count and response register
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (acc) begin
      out_valid_d = 1'b1;
      if (is_fill && (count_q != CntMax)) begin
        count_d = count_q + CntW'(1);
      end
      out_data_d.hit = !is_fill && found[CACHE_ENTRIES];
      {out_data_d.out_photoelectric, out_data_d.out_compton,
       out_data_d.out_rayleigh, out_data_d.out_pair} = front.words;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `include "keyed_lru_result_cache_assert.svh"

  `KLRC_ASSERT_NOW(a_single_hit, 1'b1, $onehot0(sel))
  `KLRC_ASSERT_NOW(a_hit_needs_entries, found[CACHE_ENTRIES], count_q != '0)
  `KLRC_ASSERT_NEXT(a_fill_grows, count_grow, count_q == $past(count_q) + CntW'(1))
  `KLRC_ASSERT_NEXT(a_lookup_keeps_count, acc && !is_fill, $stable(count_q))

endmodule

// ----- test/tb.sv -----
// testbench for keyed_lru_result_cache: directed and random traffic checked
// against a move-to-front cache predictor kept inside the bench
// depends on klrc_pkg and the keyed_lru_result_cache rtl
`timescale 1ns / 100ps

module tb;
  import klrc_pkg::*;

  localparam int unsigned Entries = DefCacheEntries;
  localparam int unsigned PoolMax = 32;

  typedef enum int {
    RX_READY,
    RX_RANDOM,
    RX_BURSTY
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_data_o;

  // predictor state: slot 0 is the front
  entry_t      cached_slot [Entries];
  int unsigned cached_count;
  rsp_t        expected_rsps [$];

  // traffic shaping
  rx_mode_e    rx_mode;
  int unsigned holdoff_left;
  int unsigned gap_max;
  int unsigned burst_left;
  int unsigned fill_pct;
  int unsigned pool_span;
  key_t        key_pool [PoolMax];
  int unsigned error_count;

  keyed_lru_result_cache i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // move-to-front cache: lookup searches valid slots only, fill pushes at front
  function automatic rsp_t predict_cache(req_t req);
    rsp_t   rsp;
    entry_t found;
    int     match;
    int     j;
    rsp = '0;
    match = -1;
    if (req.cmd == CMD_FILL) begin
      if (cached_count < Entries) cached_count++;
      for (j = int'(cached_count) - 1; j > 0; j--) cached_slot[j] = cached_slot[j-1];
      found.key.element = req.element_z;
      found.key.energy  = req.energy_bits;
      found.words[0]    = req.fill_photoelectric;
      found.words[1]    = req.fill_compton;
      found.words[2]    = req.fill_rayleigh;
      found.words[3]    = req.fill_pair;
      cached_slot[0]    = found;
    end else begin
      for (j = 0; j < int'(cached_count); j++) begin
        if (match < 0 && cached_slot[j].key.element == req.element_z &&
            cached_slot[j].key.energy == req.energy_bits) match = j;
      end
      if (match < 0) return rsp;
      found = cached_slot[match];
      for (j = match; j > 0; j--) cached_slot[j] = cached_slot[j-1];
      cached_slot[0] = found;
      rsp.hit = 1'b1;
    end
    rsp.out_photoelectric = found.words[0];
    rsp.out_compton       = found.words[1];
    rsp.out_rayleigh      = found.words[2];
    rsp.out_pair          = found.words[3];
    return rsp;
  endfunction

  function automatic req_t build_request(cmd_e cmd, logic [ElementW-1:0] element,
                                         logic [WordW-1:0] energy, logic [WordW-1:0] w0,
                                         logic [WordW-1:0] w1, logic [WordW-1:0] w2,
                                         logic [WordW-1:0] w3);
    req_t req;
    req.cmd                = cmd;
    req.element_z          = element;
    req.energy_bits        = energy;
    req.fill_photoelectric = w0;
    req.fill_compton       = w1;
    req.fill_rayleigh      = w2;
    req.fill_pair          = w3;
    return req;
  endfunction

  // mostly pool keys so lookups hit, plus near misses and unrelated keys
  function automatic req_t random_request();
    key_t key;
    int   pick;
    cmd_e cmd;
    cmd  = ($urandom_range(0, 99) < fill_pct) ? CMD_FILL : CMD_LOOKUP;
    key  = key_pool[$urandom_range(0, pool_span - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      key.energy ^= 64'd1 << $urandom_range(0, 63);
    end else if (pick < 12) begin
      key.element ^= 7'd1 << $urandom_range(0, 6);
    end else if (pick < 18) begin
      key.element = 7'($urandom_range(0, 127));
      key.energy  = random_word();
    end
    return build_request(cmd, key.element, key.energy, random_word(), random_word(),
                         random_word(), random_word());
  endfunction

  // new key set; neighbors often share one half of the key
  function automatic void refill_key_pool();
    int i;
    for (i = 0; i < int'(PoolMax); i++) begin
      key_pool[i].element = 7'($urandom_range(0, 127));
      key_pool[i].energy  = random_word();
      if (i > 0 && $urandom_range(0, 3) == 0) key_pool[i].element = key_pool[i-1].element;
      else if (i > 0 && $urandom_range(0, 5) == 0) key_pool[i].energy = key_pool[i-1].energy;
    end
  endfunction

  // send one transaction in bursts; entered and left at a falling edge
  task automatic push_request(req_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        gap = $urandom_range(1, gap_max);
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    expected_rsps.push_back(predict_cache(req));
    @(negedge clk_i);
  endtask

  // receiver stall pattern, with a counted hold-off on request
  initial begin
    int unsigned run_left;
    logic        stalling;
    out_stall_i = 1'b0;
    run_left    = 0;
    stalling    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (rx_mode)
          RX_READY: out_stall_i <= 1'b0;
          RX_RANDOM: out_stall_i <= ($urandom_range(0, 99) < 35);
          default: begin
            if (run_left == 0) begin
              stalling = !stalling;
              run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 10);
            end
            run_left--;
            out_stall_i <= stalling;
          end
        endcase
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  // compare each response transaction with the oldest prediction
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        $error("response transaction with no request pending");
        error_count++;
      end else begin
        want = expected_rsps.pop_front();
        check_field("hit", {63'd0, want.hit}, {63'd0, out_data_o.hit});
        check_field("out_photoelectric", want.out_photoelectric,
                    out_data_o.out_photoelectric);
        check_field("out_compton", want.out_compton, out_data_o.out_compton);
        check_field("out_rayleigh", want.out_rayleigh, out_data_o.out_rayleigh);
        check_field("out_pair", want.out_pair, out_data_o.out_pair);
      end
    end
  end

  // empty cache, key extremes, hit at and behind the front, duplicates
  task automatic test_basic_keys();
    logic [63:0] ones;
    ones = '1;
    // nothing valid yet, so an all-zero key must miss
    push_request(build_request(CMD_LOOKUP, 7'd0, 64'd0, ones, ones, ones, ones));
    push_request(build_request(CMD_FILL, 7'd127, ones, ones, ones, ones, ones));
    push_request(build_request(CMD_FILL, 7'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0));
    push_request(build_request(CMD_LOOKUP, 7'd0, 64'd0, ones, ones, ones, ones));
    push_request(build_request(CMD_LOOKUP, 7'd127, ones, 64'd0, 64'd0, 64'd0, 64'd0));
    // one energy bit off must miss
    push_request(build_request(CMD_LOOKUP, 7'd127, ones ^ 64'd1, 64'd0, 64'd0, 64'd0,
                               64'd0));
    // duplicate key: the newer copy sits in front
    push_request(build_request(CMD_FILL, 7'd0, 64'd0, {32{2'b01}}, {32{2'b10}},
                               {32{2'b01}}, {32{2'b10}}));
    push_request(build_request(CMD_LOOKUP, 7'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0));
  endtask

  // overflow drops the oldest entry; hit at the back moves it forward
  task automatic test_capacity();
    int i;
    for (i = 0; i <= int'(Entries); i++) begin
      push_request(build_request(CMD_FILL, 7'(i + 1), 64'h4000_0000_0000_0000 + i,
                                 random_word(), random_word(), random_word(),
                                 random_word()));
    end
    push_request(build_request(CMD_LOOKUP, 7'd1, 64'h4000_0000_0000_0000, 64'd0, 64'd0,
                               64'd0, 64'd0));
    push_request(build_request(CMD_LOOKUP, 7'd2, 64'h4000_0000_0000_0001, 64'd0, 64'd0,
                               64'd0, 64'd0));
  endtask

  // receiver holds off long while the sender keeps offering
  task automatic test_backpressure();
    gap_max   = 0;
    fill_pct  = 40;
    pool_span = 12;
    rx_mode   = RX_READY;
    // nothing on offer while the hold-off is armed
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    holdoff_left = 150;
    @(negedge clk_i);
    repeat (40) push_request(random_request());
  endtask

  // random traffic in phases with varied key sets and idling
  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 13; phase++) begin
      if (phase % 3 == 0) refill_key_pool();
      fill_pct  = $urandom_range(15, 50);
      pool_span = (phase == 0) ? 12 : $urandom_range(2, PoolMax);
      case (phase % 4)
        0: begin
          gap_max = 0;
          rx_mode = RX_READY;
        end
        1: begin
          gap_max = 8;
          rx_mode = RX_RANDOM;
        end
        2: begin
          gap_max = 3;
          rx_mode = RX_BURSTY;
        end
        default: begin
          gap_max = 0;
          rx_mode = RX_BURSTY;
        end
      endcase
      repeat (100) push_request(random_request());
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    rx_mode      = RX_READY;
    holdoff_left = 0;
    gap_max      = 0;
    burst_left   = 0;
    fill_pct     = 30;
    pool_span    = 8;
    cached_count = 0;
    error_count  = 0;
    refill_key_pool();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_keys();
    test_capacity();
    test_backpressure();
    test_random_traffic();

    // drain
    in_valid_i <= 1'b0;
    rx_mode = RX_READY;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
